// ===== rtl/core/stroke_quad_tessellator_assert.svh =====
// assertion macros shared by the tessellator rtl
`ifndef STROKE_QUAD_TESSELLATOR_ASSERT_SVH
`define STROKE_QUAD_TESSELLATOR_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define SQT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tessellator assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SQT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tessellator assertion failed");

`endif

// ===== rtl/core/sqt_pkg.sv =====
// shared types, constants and helpers of the stroke quad tessellator
package sqt_pkg;

   localparam int COORD_W = 24;
   localparam int HW_W    = 16;
   localparam int INDEX_W = 16;
   localparam int SQRT_GUARD = 6;
   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS  = 17;
   localparam int CNT_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_HALF_WIDTH = 1'b0;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      new_stroke;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        quad_index;
      logic signed [COORD_W-1:0] corner0_x;
      logic signed [COORD_W-1:0] corner0_y;
      logic signed [COORD_W-1:0] corner1_x;
      logic signed [COORD_W-1:0] corner1_y;
      logic signed [COORD_W-1:0] corner2_x;
      logic signed [COORD_W-1:0] corner2_y;
      logic signed [COORD_W-1:0] corner3_x;
      logic signed [COORD_W-1:0] corner3_y;
      logic                      joint_shared;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic sq_en;
      logic sum_en;
      logic sqrt_step;
      logic mul_en;
      logic div_step;
      logic corner_en;
   } cmd_type;

   typedef struct packed {
      logic seg;
      logic out_free;
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SQR  = 7'b0000010,
      ST_SUM  = 7'b0000100,
      ST_SQRT = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_CORN = 7'b1000000
   } state_type;

   function automatic logic [COORD_W-1:0] sat24(input logic signed [27:0] v);
      logic [COORD_W-1:0] r;
      if (v > 28'sd8388607) begin
         r = 24'h7FFFFF;
      end else if (v < -28'sd8388608) begin
         r = 24'h800000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/stroke_quad_tessellator.sv =====
// top level of the stroke quad tessellator: csr port, sequencer and datapath
// a point that closes a segment passes the square, sum, root, multiply, divide and corner states before its quad beat
// later points stall until that quad is done, a wait dominated by the 31-step square root
//   and the 17-step scaling divide; a first point of a stroke only loads the stroke state
// the next point is taken while a finished quad still waits in the output register
// reset (synchronous, active high) clears the stroke state and sets half width to 3.0
module stroke_quad_tessellator
   import sqt_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // point beats in
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // quad beats out
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // default half width is 3.0 in the coordinate format
   localparam logic [HW_W-1:0] HW_RESET = HW_W'(3 << COORD_FRAC_BITS);

   logic [HW_W-1:0] half_width_ff;
   logic            csr_wr;
   logic            csr_hit;
   cmd_type         cmd;
   status_type      status;

   // register port: always ready, single half width register at byte address zero, decoded on address bit 2 only
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_IDX_HALF_WIDTH);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {16'b0, half_width_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= HW_RESET;
      end else if (csr_wr && csr_hit) begin
         half_width_ff <= csr_pwdata[HW_W-1:0];
      end
   end

   // sequencer: walks squares, sum, root, multiply, divide and corner steps
   sqt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: all arithmetic and stroke state, plus the output register
   sqt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_data),
      .half_width (half_width_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/core/sqt_ctrl.sv =====
// sequencer for the tessellator datapath
module sqt_ctrl
   import sqt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept && status.seg) state_in = ST_SQR;
         end
         ST_SQR: begin
            cmd.sq_en = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            cnt_in     = CNT_W'(SQRT_STEPS - 1);
            state_in   = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            cnt_in     = CNT_W'(DIV_STEPS - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_CORN;
         end
         ST_CORN: begin
            cmd.corner_en = status.out_free;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`include "stroke_quad_tessellator_assert.svh"
   `SQT_ASSERT_NXT(a_seg_starts, accept && status.seg, state_ff == ST_SQR)
   `SQT_ASSERT_NXT(a_first_point_idle, accept && !status.seg, state_ff == ST_IDLE)
   `SQT_ASSERT_NXT(a_corner_holds, state_ff == ST_CORN && !status.out_free,
                   state_ff == ST_CORN)
   `SQT_ASSERT_IMP(a_sqrt_cnt_range, state_ff == ST_SQRT, cnt_ff < CNT_W'(SQRT_STEPS))

endmodule

// ===== rtl/core/sqt_dpath.sv =====
// segment arithmetic: squares, square root, scaling divide, corners and stroke state
module sqt_dpath
   import sqt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output status_type      status,
   input  req_type         req_data,
   input  logic [HW_W-1:0] half_width,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

   logic signed [COORD_W-1:0] last_x_ff, last_y_ff, bx_ff, by_ff;
   logic signed [COORD_W-1:0] loff_x_ff, loff_y_ff;
   logic                      point_seen_ff, quad_seen_ff;
   logic [INDEX_W-1:0]        quad_count_ff;
   logic signed [24:0]        dx_ff, dy_ff;
   logic [48:0]               sqx_ff, sqy_ff;
   logic [61:0]               v_ff, r_ff, bit_ff;
   logic [47:0]               remx_ff, remy_ff;
   logic [46:0]               dvs_ff;
   logic [DIV_STEPS-1:0]      qx_ff, qy_ff;
   logic                      negx_ff, negy_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic signed [49:0] sqx_full, sqy_full;
   logic [49:0]        s_sum;
   logic [61:0]        trial;
   logic [30:0]        len;
   logic [24:0]        magx, magy;
   logic [40:0]        prodx, prody;
   logic signed [25:0] cx, cy, cqx, cqy;
   logic signed [27:0] ax, ay, bx, by, cx_w, cy_w, lx, ly;
   logic signed [27:0] t0x, t0y, t3x, t3y;

   assign status.seg      = point_seen_ff && !req_data.new_stroke;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;
   assign s_sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign trial    = r_ff + bit_ff;
   assign len      = r_ff[30:0];

   assign magx  = dy_ff[24] ? 25'(-dy_ff) : 25'(dy_ff);
   assign magy  = dx_ff[24] ? 25'(-dx_ff) : 25'(dx_ff);
   assign prodx = 41'(magx) * 41'(half_width);
   assign prody = 41'(magy) * 41'(half_width);

   // offset components; zero length gives zero offset
   assign cqx = $signed({9'b0, qx_ff});
   assign cqy = $signed({9'b0, qy_ff});
   assign cx  = (len == '0) ? 26'sd0 : (negx_ff ? -cqx : cqx);
   assign cy  = (len == '0) ? 26'sd0 : (negy_ff ? -cqy : cqy);

   assign ax   = 28'(last_x_ff);
   assign ay   = 28'(last_y_ff);
   assign bx   = 28'(bx_ff);
   assign by   = 28'(by_ff);
   assign cx_w = 28'(cx);
   assign cy_w = 28'(cy);
   assign lx   = 28'(loff_x_ff);
   assign ly   = 28'(loff_y_ff);

   always_comb begin
      t3x = ax + cx_w;
      t3y = ay + cy_w;
      t0x = ax - cx_w;
      t0y = ay - cy_w;
      if (quad_seen_ff) begin
         t3x = (ax + lx + t3x) >>> 1;
         t3y = (ay + ly + t3y) >>> 1;
         t0x = (ax - lx + t0x) >>> 1;
         t0y = (ay - ly + t0y) >>> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_seen_ff <= 1'b0;
         quad_seen_ff  <= 1'b0;
         quad_count_ff <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         loff_x_ff     <= '0;
         loff_y_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load && !status.seg) begin
            point_seen_ff <= 1'b1;
            last_x_ff     <= req_data.point_x;
            last_y_ff     <= req_data.point_y;
            if (req_data.new_stroke) begin
               quad_seen_ff  <= 1'b0;
               quad_count_ff <= '0;
               loff_x_ff     <= '0;
               loff_y_ff     <= '0;
            end
         end
         if (cmd.corner_en) begin
            quad_seen_ff <= 1'b1;
            if (quad_count_ff != '1) quad_count_ff <= quad_count_ff + 1'b1;
            loff_x_ff    <= cx[COORD_W-1:0];
            loff_y_ff    <= cy[COORD_W-1:0];
            last_x_ff    <= bx_ff;
            last_y_ff    <= by_ff;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bx_ff <= req_data.point_x;
         by_ff <= req_data.point_y;
         dx_ff <= 25'(last_x_ff) - 25'(req_data.point_x);
         dy_ff <= 25'(last_y_ff) - 25'(req_data.point_y);
      end
      if (cmd.sq_en) begin
         sqx_ff <= sqx_full[48:0];
         sqy_ff <= sqy_full[48:0];
      end
      if (cmd.sum_en) begin
         v_ff   <= {s_sum[49:0], 12'b0};
         r_ff   <= '0;
         bit_ff <= 62'(1) << 60;
      end
      if (cmd.sqrt_step) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.mul_en) begin
         remx_ff <= {1'b0, prodx, 6'b0} + 48'(len >> 1);
         remy_ff <= {1'b0, prody, 6'b0} + 48'(len >> 1);
         dvs_ff  <= {len, 16'b0};
         qx_ff   <= '0;
         qy_ff   <= '0;
         negx_ff <= !dy_ff[24] && (dy_ff != '0);
         negy_ff <= dx_ff[24];
      end
      if (cmd.div_step) begin
         if (remx_ff >= 48'(dvs_ff)) begin
            remx_ff <= remx_ff - 48'(dvs_ff);
            qx_ff   <= {qx_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            qx_ff   <= {qx_ff[DIV_STEPS-2:0], 1'b0};
         end
         if (remy_ff >= 48'(dvs_ff)) begin
            remy_ff <= remy_ff - 48'(dvs_ff);
            qy_ff   <= {qy_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            qy_ff   <= {qy_ff[DIV_STEPS-2:0], 1'b0};
         end
         dvs_ff <= dvs_ff >> 1;
      end
      if (cmd.corner_en) begin
         rsp_ff.quad_index   <= quad_count_ff;
         rsp_ff.corner0_x    <= sat24(t0x);
         rsp_ff.corner0_y    <= sat24(t0y);
         rsp_ff.corner1_x    <= sat24(bx - cx_w);
         rsp_ff.corner1_y    <= sat24(by - cy_w);
         rsp_ff.corner2_x    <= sat24(bx + cx_w);
         rsp_ff.corner2_y    <= sat24(by + cy_w);
         rsp_ff.corner3_x    <= sat24(t3x);
         rsp_ff.corner3_y    <= sat24(t3y);
         rsp_ff.joint_shared <= quad_seen_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "stroke_quad_tessellator_assert.svh"
   `SQT_ASSERT_NXT(a_rsp_after_corner, cmd.corner_en, rsp_valid_ff && quad_seen_ff)
   `SQT_ASSERT_NXT(a_first_point_seen, cmd.load && !status.seg, point_seen_ff)
   `SQT_ASSERT_IMP(a_no_overwrite, cmd.corner_en, status.out_free)

endmodule
